/* hw/rtl/quantized_dot_product_requant_top_macros.svh */
// ----------------------------------------------------------------------------
// quantized_dot_product_requant_top_macros
// assertion macros used by the checker of the requantizer block
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_DOT_PRODUCT_REQUANT_TOP_MACROS_SVH
`define QUANTIZED_DOT_PRODUCT_REQUANT_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define QDPR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define QDPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/qdpr_pkg.sv */
// ----------------------------------------------------------------------------
// qdpr_pkg
// types and constants of the quantized dot product requantizer
// ----------------------------------------------------------------------------
package qdpr_pkg;

	localparam int ACC_WIDTH = 32;
	localparam int LO_PROD_W = 33 + ACC_WIDTH;

	localparam int QDPR_Q_DEPTH = 2;
	localparam int QDPR_Q_AW = (QDPR_Q_DEPTH > 1) ? $clog2(QDPR_Q_DEPTH) : 1;
	localparam int QDPR_Q_CW = $clog2(QDPR_Q_DEPTH + 1);

	// queue entries plus three back stages plus the output register
	localparam int QDPR_MAX_PENDING = QDPR_Q_DEPTH + 4;
	localparam int QDPR_PEND_W = $clog2(QDPR_MAX_PENDING + 1);

	localparam logic [7:0] QDPR_OUT_MAX = 8'd255;

	localparam int QDPR_CFG_IW = 1;
	localparam int QDPR_CFG_DW = 8;

	typedef enum logic [QDPR_CFG_IW-1:0] {
		REG_RELU_ENABLE    = 1'b0,
		REG_OUT_ZERO_POINT = 1'b1
	} qdpr_reg_t;

	typedef struct packed {
		logic [ACC_WIDTH-1:0] sum;
		logic [63:0]          multiplier;
		logic [63:0]          bias;
		logic [5:0]           shift_amount;
	} qdpr_job_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} qdpr_qstat_t;

endpackage

/* hw/rtl/qdpr_front.sv */
// ----------------------------------------------------------------------------
// qdpr_front
// accepts words, runs the multiply-accumulate and hands finished sums on
// ----------------------------------------------------------------------------
module qdpr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                activation,
	input  logic signed [7:0]         weight,
	input  logic                      last_term,
	input  logic signed [63:0]        multiplier,
	input  logic signed [63:0]        bias,
	input  logic [5:0]                shift_amount,
	input  qdpr_pkg::qdpr_qstat_t     q_stat,
	output logic                      push,
	output qdpr_pkg::qdpr_job_t       job
);
	import qdpr_pkg::*;

	logic [ACC_WIDTH-1:0] acc_q;
	logic signed [16:0]   prod;
	logic [ACC_WIDTH-1:0] prod_ext;
	logic [ACC_WIDTH-1:0] sum;
	logic                 accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	assign prod     = $signed({1'b0, activation}) * weight;
	assign prod_ext = ACC_WIDTH'(prod);
	assign sum      = acc_q + prod_ext;

	assign push             = accept && last_term;
	assign job.sum          = sum;
	assign job.multiplier   = multiplier;
	assign job.bias         = bias;
	assign job.shift_amount = shift_amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			if (last_term) begin
				acc_q <= '0;
			end else begin
				acc_q <= sum;
			end
		end
	end

endmodule

/* hw/rtl/qdpr_queue.sv */
// ----------------------------------------------------------------------------
// qdpr_queue
// short register queue of finished sums between front and back
// ----------------------------------------------------------------------------
module qdpr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  qdpr_pkg::qdpr_job_t   push_job,
	input  logic                  pop,
	output qdpr_pkg::qdpr_job_t   pop_job,
	output qdpr_pkg::qdpr_qstat_t q_stat
);
	import qdpr_pkg::*;

	qdpr_job_t              mem_q [QDPR_Q_DEPTH];
	logic [QDPR_Q_AW-1:0]   wr_ptr_q;
	logic [QDPR_Q_AW-1:0]   rd_ptr_q;
	logic [QDPR_Q_CW-1:0]   cnt_q;

	assign q_stat.full      = (cnt_q == QDPR_Q_CW'(QDPR_Q_DEPTH));
	assign q_stat.not_empty = (cnt_q != '0);
	assign pop_job          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QDPR_Q_AW'(QDPR_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QDPR_Q_AW'(QDPR_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/qdpr_back.sv */
// ----------------------------------------------------------------------------
// qdpr_back
// requantize pipeline: split 64-bit multiply, bias add, shift and clamp
// ----------------------------------------------------------------------------
module qdpr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qdpr_pkg::qdpr_qstat_t q_stat,
	input  qdpr_pkg::qdpr_job_t   job,
	output logic                  pop,
	input  logic [7:0]            low_bound,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte
);
	import qdpr_pkg::*;

	logic                        advance;
	logic signed [LO_PROD_W-1:0] lo_prod;
	logic [31:0]                 sum32;
	logic [31:0]                 hi_prod;
	logic signed [63:0]          shifted;
	logic [31:0]                 x;
	logic [7:0]                  clamped;

	logic               v_s1;
	logic [63:0]        lo_s1;
	logic [31:0]        hi_s1;
	logic [63:0]        bias_s1;
	logic [5:0]         sh_s1;
	logic               v_s2;
	logic [63:0]        t_s2;
	logic [63:0]        bias_s2;
	logic [5:0]         sh_s2;
	logic               v_s3;
	logic signed [63:0] t_s3;
	logic [5:0]         sh_s3;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && q_stat.not_empty;

	// low half of multiplier is unsigned, sum is signed
	assign lo_prod = $signed({1'b0, job.multiplier[31:0]}) * $signed(job.sum);
	assign sum32   = 32'($signed(job.sum));
	assign hi_prod = job.multiplier[63:32] * sum32;

	assign shifted = t_s3 >>> sh_s3;
	assign x       = shifted[31:0];

	always_comb begin
		priority if (x[31]) begin
			clamped = low_bound;
		end else if (x < {24'd0, low_bound}) begin
			clamped = low_bound;
		end else if (x > {24'd0, QDPR_OUT_MAX}) begin
			clamped = QDPR_OUT_MAX;
		end else begin
			clamped = x[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lo_s1      <= 64'(lo_prod);
			hi_s1      <= hi_prod;
			bias_s1    <= job.bias;
			sh_s1      <= job.shift_amount;
			t_s2       <= lo_s1 + {hi_s1, 32'd0};
			bias_s2    <= bias_s1;
			sh_s2      <= sh_s1;
			t_s3       <= t_s2 + bias_s2;
			sh_s3      <= sh_s2;
			out_byte_q <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= q_stat.not_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

/* hw/rtl/quantized_dot_product_requant_top.sv */
// ----------------------------------------------------------------------------
// quantized_dot_product_requant_top
// uint8 x int8 dot product with 64-bit requantization to one output byte
// ----------------------------------------------------------------------------
// Takes one activation/weight word per cycle while not stalled into a 32-bit
// wrapping accumulator; the 8x9 multiply-accumulate in the front sets that
// rate. A word with last_term set closes the sum and moves it, with its
// multiplier, bias and shift, into a two-entry queue. The back pipeline takes
// one entry per cycle while the output is not held, through the split 64x32
// multiply, partial-product add, bias add, then shift and clamp into the
// output register. The front stalls only when the queue is full, which happens
// when the output side is held. relu_enable and out_zero_point are to be
// written through the cfg port only while idle; the block does not enforce it.
module quantized_dot_product_requant_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       activation,
	input  logic signed [7:0]                weight,
	input  logic                             last_term,
	input  logic signed [63:0]               multiplier,
	input  logic signed [63:0]               bias,
	input  logic [5:0]                       shift_amount,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	input  logic                             cfg_we,
	input  logic [qdpr_pkg::QDPR_CFG_IW-1:0] cfg_index,
	input  logic [qdpr_pkg::QDPR_CFG_DW-1:0] cfg_data
);
	import qdpr_pkg::*;

	logic        relu_enable_q;
	logic [7:0]  out_zero_point_q;
	logic [7:0]  low_bound;
	logic        push;
	logic        pop;
	qdpr_job_t   push_job;
	qdpr_job_t   pop_job;
	qdpr_qstat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_enable_q    <= 1'b0;
			out_zero_point_q <= '0;
		end else if (cfg_we) begin
			unique case (qdpr_reg_t'(cfg_index))
				REG_RELU_ENABLE: begin
					relu_enable_q <= cfg_data[0];
				end
				REG_OUT_ZERO_POINT: begin
					out_zero_point_q <= cfg_data[7:0];
				end
			endcase
		end
	end

	assign low_bound = relu_enable_q ? out_zero_point_q : 8'd0;

	qdpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.activation   (activation),
		.weight       (weight),
		.last_term    (last_term),
		.multiplier   (multiplier),
		.bias         (bias),
		.shift_amount (shift_amount),
		.q_stat       (q_stat),
		.push         (push),
		.job          (push_job)
	);

	qdpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	qdpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.job       (pop_job),
		.pop       (pop),
		.low_bound (low_bound),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte)
	);

endmodule

/* hw/rtl/qdpr_checker.sv */
// ----------------------------------------------------------------------------
// qdpr_checker
// port-level checks of the requantizer, bound to the top level
// ----------------------------------------------------------------------------
`include "quantized_dot_product_requant_top_macros.svh"

module qdpr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             last_term,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [7:0]                       out_byte,
	input logic                             cfg_we,
	input logic [qdpr_pkg::QDPR_CFG_IW-1:0] cfg_index,
	input logic [qdpr_pkg::QDPR_CFG_DW-1:0] cfg_data
);
	import qdpr_pkg::*;

	logic                   relu_sh_q;
	logic [7:0]             zp_sh_q;
	logic [QDPR_PEND_W-1:0] pend_q;
	logic                   last_acc;
	logic                   out_acc;

	assign last_acc = in_valid && !in_stall && last_term;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_sh_q <= 1'b0;
			zp_sh_q   <= '0;
			pend_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_RELU_ENABLE) begin
				relu_sh_q <= cfg_data[0];
			end
			if (cfg_we && cfg_index == REG_OUT_ZERO_POINT) begin
				zp_sh_q <= cfg_data[7:0];
			end
			if (last_acc && !out_acc) begin
				pend_q <= pend_q + 1'b1;
			end else if (out_acc && !last_acc) begin
				pend_q <= pend_q - 1'b1;
			end
		end
	end

	`QDPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled output word changed")
	`QDPR_ASSERT_NOW(a_no_orphan, pend_q == '0, !out_valid, "output word without a closed sum")
	`QDPR_ASSERT_NOW(a_pend_cap, 1'b1, pend_q <= QDPR_PEND_W'(QDPR_MAX_PENDING), "more sums in flight than storage")
	`QDPR_ASSERT_NOW(a_relu_floor, out_valid && relu_sh_q, out_byte >= zp_sh_q, "output below zero point with relu")

endmodule

bind quantized_dot_product_requant_top qdpr_checker u_qdpr_checker (.*);
